/* rtl/core/mx3i_pkg.sv */
`default_nettype none
package mx3i_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // cofactor i = m[a]*m[b] - m[c]*m[d], elements in row-major order
  localparam int unsigned COF_IDX [9][4] = '{
    '{4, 8, 7, 5},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{3, 2, 0, 5},
    '{3, 7, 6, 4},
    '{6, 1, 0, 7},
    '{0, 4, 3, 1}
  };

endpackage
`default_nettype wire

/* rtl/core/mx3i_cofactor.sv */
`default_nettype none
module mx3i_cofactor #(
  parameter int unsigned W = mx3i_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] m [9],
  output logic signed [2*W:0]      cof [9],
  output logic signed [W-1:0]      mr [3]
);

  logic signed [2*W-1:0] pa [9];
  logic signed [2*W-1:0] pb [9];
  logic signed [W-1:0]   mq [3];

  for (genvar i = 0; i < 9; i++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        pa[i]  <= m[mx3i_pkg::COF_IDX[i][0]] * m[mx3i_pkg::COF_IDX[i][1]];
        pb[i]  <= m[mx3i_pkg::COF_IDX[i][2]] * m[mx3i_pkg::COF_IDX[i][3]];
        cof[i] <= (2*W+1)'(pa[i]) - (2*W+1)'(pb[i]);
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        mq[j] <= m[j];
        mr[j] <= mq[j];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mx3i_det.sv */
`default_nettype none
module mx3i_det #(
  parameter int unsigned W = mx3i_pkg::DATA_WIDTH_DEF,
  localparam int unsigned DTW = 3*W + 3
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [2*W:0] cof [9],
  input  wire logic signed [W-1:0] mr [3],
  output logic signed [DTW-1:0]    det,
  output logic signed [2*W:0]      cofd [9]
);

  logic signed [2*W:0]   pl [3];
  logic signed [2*W:0]   ph [3];
  logic signed [2*W:0]   cof1 [9];
  logic signed [DTW-1:0] term [3];

  for (genvar j = 0; j < 3; j++) begin : g_pp
    always_ff @(posedge clk) begin
      if (en) begin
        pl[j] <= mr[j] * $signed({1'b0, cof[3*j][W-1:0]});
        ph[j] <= mr[j] * $signed(cof[3*j][2*W:W]);
      end
    end
    assign term[j] = (DTW'(ph[j]) <<< W) + DTW'(pl[j]);
  end

  for (genvar i = 0; i < 9; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        cof1[i] <= cof[i];
        cofd[i] <= cof1[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= term[0] + term[1] + term[2];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mx3i_div.sv */
`default_nettype none
module mx3i_div #(
  parameter int unsigned W = mx3i_pkg::DATA_WIDTH_DEF,
  parameter int unsigned F = mx3i_pkg::FRAC_BITS_DEF,
  localparam int unsigned DTW = 3*W + 3
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [2*W:0]  cof,
  input  wire logic signed [DTW-1:0] det,
  output logic signed [W-1:0]       res,
  output logic                      sat,
  output logic                      zero
);

  localparam int unsigned NW = 2*W + 1 + 2*F;
  localparam int unsigned RW = ((NW > DTW + W) ? NW : DTW + W) + 1;

  logic [RW-1:0]  r    [W+1];
  logic [DTW-1:0] d    [W+1];
  logic [W:0]     q    [W+2];
  logic           neg  [W+2];
  logic           zr   [W+2];

  logic [2*W:0]   cmag;
  logic [DTW-1:0] dmag;
  logic [W-1:0]   lim;
  logic [W-1:0]   qq;
  logic [W-1:0]   v;
  logic           s;

  assign cmag = cof[2*W] ? (2*W+1)'(-cof) : (2*W+1)'(cof);
  assign dmag = det[DTW-1] ? DTW'(-det) : DTW'(det);

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]   <= RW'(cmag) << (2*F);
      d[0]   <= dmag;
      q[0]   <= '0;
      neg[0] <= cof[2*W] ^ det[DTW-1];
      zr[0]  <= (det == '0);
    end
  end

  for (genvar k = 0; k <= W; k++) begin : g_step
    logic [RW-1:0] dsh;
    logic          hit;
    assign dsh = RW'(d[k]) << (W - k);
    assign hit = (r[k] >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        q[k+1]   <= {q[k][W-1:0], hit};
        neg[k+1] <= neg[k];
        zr[k+1]  <= zr[k];
      end
    end
    if (k < W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r[k+1] <= hit ? r[k] - dsh : r[k];
          d[k+1] <= d[k];
        end
      end
    end
  end

  assign lim = {1'b0, {(W-1){1'b1}}} + W'(neg[W+1]);
  assign qq  = q[W+1][W-1:0];
  assign s   = q[W+1][W] || (qq > lim);
  assign v   = s ? lim : qq;

  always_ff @(posedge clk) begin
    if (en) begin
      res  <= zr[W+1] ? '0 : (neg[W+1] ? $signed(-v) : $signed(v));
      sat  <= !zr[W+1] && s;
      zero <= zr[W+1];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/matrix3x3_inverse_core.sv */
`default_nettype none
// channel | dir | tdata (low bit up)                | tuser
// s_axis  | in  | m00 m01 m02 m10 m11 m12 m20 m21 m22 | -
// m_axis  | out | inv00 .. inv22 (row-major)         | singular, saturated
// One item per cycle while the output is not stalled. The pipeline holds 4
// cofactor/determinant stages, one stage per quotient bit in the restoring
// divider, plus sign and saturation stages. Reset clears the valid bits only.
// A stall at the output holds every stage in place; s_tready follows it.
module matrix3x3_inverse_core #(
  parameter int unsigned DATA_WIDTH = mx3i_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = mx3i_pkg::FRAC_BITS_DEF,
  localparam int unsigned TW = ((9*DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [TW-1:0] s_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [TW-1:0]      m_tdata,   // inv00 inv01 inv02 inv10 .. inv22
  output logic [7:0]         m_tuser    // singular, saturated, zero fill
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned DTW = 3*W + 3;
  localparam int unsigned L   = W + 7;

  logic                  en;
  logic [L-1:0]          vld;
  logic signed [W-1:0]   m    [9];
  logic signed [2*W:0]   cof  [9];
  logic signed [W-1:0]   mr   [3];
  logic signed [DTW-1:0] det;
  logic signed [2*W:0]   cofd [9];
  logic signed [W-1:0]   res  [9];
  logic [8:0]            sat;
  logic [8:0]            zero;

  assign en       = !vld[L-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], s_tvalid};
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_io
    assign m[i] = $signed(s_tdata[i*W +: W]);
    assign m_tdata[i*W +: W] = res[i];
  end
  if (TW > 9*W) begin : g_pad
    assign m_tdata[TW-1:9*W] = '0;
  end

  assign m_tuser = {6'd0, |sat, |zero};

  mx3i_cofactor #(.W(W)) u_cof (
    .clk (clk),
    .en  (en),
    .m   (m),
    .cof (cof),
    .mr  (mr)
  );

  mx3i_det #(.W(W)) u_det (
    .clk  (clk),
    .en   (en),
    .cof  (cof),
    .mr   (mr),
    .det  (det),
    .cofd (cofd)
  );

  for (genvar i = 0; i < 9; i++) begin : g_div
    mx3i_div #(.W(W), .F(FRAC_BITS)) u_div (
      .clk  (clk),
      .en   (en),
      .cof  (cofd[i]),
      .det  (det),
      .res  (res[i]),
      .sat  (sat[i]),
      .zero (zero[i])
    );
  end

endmodule
`default_nettype wire

/* sim/mx3i_checker.sv */
module mx3i_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [287:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [287:0] m_tdata,
  input  logic [7:0]   m_tuser,
  output int           errors,
  output int           outstanding
);

  typedef struct {
    logic [287:0] inv;
    logic         singular;
    logic         saturated;
  } inverse_t;

  inverse_t pending_inverses[$];

  function automatic inverse_t invert_matrix(input logic [287:0] d);
    logic signed [191:0] m[9];
    logic signed [191:0] c[9];
    logic signed [191:0] det, dabs, num, q, lim;
    logic neg;
    inverse_t r;
    for (int i = 0; i < 9; i++) begin
      m[i] = 192'(signed'(d[32*i +: 32]));
    end
    c[0] = m[4]*m[8] - m[7]*m[5];
    c[1] = m[2]*m[7] - m[1]*m[8];
    c[2] = m[1]*m[5] - m[2]*m[4];
    c[3] = m[5]*m[6] - m[3]*m[8];
    c[4] = m[0]*m[8] - m[2]*m[6];
    c[5] = m[3]*m[2] - m[0]*m[5];
    c[6] = m[3]*m[7] - m[6]*m[4];
    c[7] = m[6]*m[1] - m[0]*m[7];
    c[8] = m[0]*m[4] - m[3]*m[1];
    det = m[0]*c[0] + m[1]*c[3] + m[2]*c[6];
    r.inv = '0;
    r.saturated = 1'b0;
    r.singular = (det == 0);
    if (!r.singular) begin
      dabs = (det < 0) ? -det : det;
      for (int i = 0; i < 9; i++) begin
        num = c[i] <<< 32;
        neg = (num < 0) ^ (det < 0);
        if (num < 0) num = -num;
        q = num / dabs;
        lim = 192'(64'h7FFF_FFFF) + 192'(neg);
        if (q > lim) begin
          r.saturated = 1'b1;
          q = lim;
        end
        if (neg) q = -q;
        r.inv[32*i +: 32] = q[31:0];
      end
    end
    return r;
  endfunction

  initial begin
    errors = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    inverse_t want;
    logic bad;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pending_inverses.push_back(invert_matrix(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        if (pending_inverses.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected item %h %b", m_tdata, m_tuser[1:0]);
        end else begin
          want = pending_inverses.pop_front();
          bad = (want.singular !== m_tuser[0]) || (want.saturated !== m_tuser[1]);
          for (int i = 0; i < 9; i++) begin
            if (want.inv[32*i +: 32] !== m_tdata[32*i +: 32]) bad = 1'b1;
          end
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              for (int i = 0; i < 9; i++) begin
                if (want.inv[32*i +: 32] !== m_tdata[32*i +: 32])
                  $display("inv%0d%0d: expected %h got %h", i / 3, i % 3,
                           want.inv[32*i +: 32], m_tdata[32*i +: 32]);
              end
              $display("singular/saturated: expected %b%b got %b%b",
                       want.singular, want.saturated, m_tuser[0], m_tuser[1]);
            end
          end
        end
      end
      outstanding = pending_inverses.size();
    end
  end

endmodule

/* sim/tb.sv */
module tb;

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [287:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [287:0] m_tdata;
  logic [7:0]   m_tuser;
  int           errors;
  int           outstanding;
  int           idle_pct;
  int           stall_pct;
  int           hold_req;
  int           hold_left;

  matrix3x3_inverse_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  mx3i_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [287:0] mat9(input logic [31:0] a0, a1, a2, a3, a4, a5,
                                        a6, a7, a8);
    return {a8, a7, a6, a5, a4, a3, a2, a1, a0};
  endfunction

  function automatic logic [31:0] rand_element();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($urandom_range(32'h8_0000) - 32'h4_0000);
      4, 5:       return $urandom;
      6:          return 32'h0;
      7:          return 32'($urandom_range(16) - 8);
      8:          return $urandom_range(1) ? MAXV : MINV;
      default:    return 32'($signed($urandom) >>> $urandom_range(24));
    endcase
  endfunction

  function automatic logic [287:0] rand_matrix();
    logic [287:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = rand_element();
    if ($urandom_range(9) == 0) d[287:192] = d[95:0];
    return d;
  endfunction

  task automatic send_matrix(input logic [287:0] d);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_matrix(mat9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_matrix(mat9(ONE*2, 0, 0, 0, ONE*2, 0, 0, 0, ONE*2));
    send_matrix(mat9(ONE/2, 0, 0, 0, -ONE, 0, 0, 0, ONE*4));
    send_matrix('0);
    send_matrix({288{1'b1}});
    send_matrix(mat9(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(mat9(-1, 0, 0, 0, 1, 0, 0, 0, -1));
    send_matrix(mat9(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    send_matrix(mat9(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
    send_matrix(mat9(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV));
    send_matrix(mat9(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV));
    send_matrix(mat9(MAXV, MINV, 0, MINV, MAXV, 0, 0, 0, MINV));
    send_matrix(mat9(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));
    send_matrix(mat9(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
    send_matrix(mat9(ONE*2, 0, ONE, ONE, ONE*3, ONE*2, ONE, ONE, ONE));
    send_matrix(mat9(ONE, ONE*2, ONE*3, 0, ONE, ONE*4, 0, 0, ONE));
    send_matrix(mat9(ONE, ONE*2, ONE*3, ONE*4, ONE*5, ONE*6, ONE*7, ONE*8, ONE*9));
    send_matrix(mat9(ONE, ONE*2, ONE*3, ONE*4, ONE*5, ONE*6, ONE, ONE*2, ONE*3));
    send_matrix(mat9(ONE*3, 1, 0, 1, ONE*3, 1, 0, 1, ONE*3));
    send_matrix(mat9(32'h5555_5555, 32'hAAAA_AAAA, 1, 2, 32'h5555_5555, 3,
                     32'hAAAA_AAAA, 4, 32'h5555_5555));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 22 : 72) : 0;
      stall_pct = (phase == 2) ? 72 : ((phase == 3) ? 22 : 0);
      for (int n = 0; n < 110; n++) send_matrix(rand_matrix());
      drain();
    end

    idle_pct = 0;
    stall_pct = 10;
    hold_req = 300;
    for (int n = 0; n < 60; n++) send_matrix(rand_matrix());
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mx3i_pkg.sv
rtl/core/mx3i_cofactor.sv
rtl/core/mx3i_det.sv
rtl/core/mx3i_div.sv
rtl/core/matrix3x3_inverse_core.sv
sim/mx3i_checker.sv
sim/tb.sv
